// File: hw/rtl/grid_value_record_framer_defines.svh
// Assertion macros used by the checker file of the grid value record framer.
// Needs a clock named clk and an active-low reset named rst_n in the using scope.
`ifndef GRID_VALUE_RECORD_FRAMER_DEFINES_SVH
`define GRID_VALUE_RECORD_FRAMER_DEFINES_SVH

// Same-cycle implication, disabled while reset is held.
`define GVRF_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("gvrf same-cycle check failed");

// Next-cycle implication, disabled while reset is held.
`define GVRF_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("gvrf next-cycle check failed");

`endif

// File: hw/rtl/gvrf_pkg.sv
// Shared types, constants and a helper function of the grid value record framer.
// No dependencies; every module of the block imports this package.
package gvrf_pkg;

  localparam int COUNT_WIDTH_DEF = 25;
  localparam int DATA_W          = 32;
  localparam int RECV_W          = 8;
  localparam int TOTAL_W         = 25;
  localparam int LEN_W           = 10;
  localparam int ADDR_W          = 4;

  localparam logic [DATA_W-1:0]  UNDEF_RESET = 32'd1259902492;
  localparam logic [RECV_W-1:0]  RECV_RESET  = 8'd8;
  localparam logic [TOTAL_W-1:0] TOTAL_RESET = 25'd1;

  // Register index, taken from paddr[3:2].
  typedef enum logic [1:0] {
    REG_UNDEFINED_VALUE = 2'd0,
    REG_RECORD_VALUES   = 2'd1,
    REG_TOTAL_VALUES    = 2'd2
  } gvrf_reg_t;

  // Kind of an emitted word, carried on out_tuser.
  typedef enum logic [1:0] {
    KIND_LEAD  = 2'd0,
    KIND_VALUE = 2'd1,
    KIND_TRAIL = 2'd2
  } gvrf_kind_t;

  typedef struct packed {
    logic [DATA_W-1:0]  undefined_value;
    logic [RECV_W-1:0]  record_values;
    logic [TOTAL_W-1:0] total_values;
  } gvrf_cfg_t;

  // Everything the output side needs to emit the words of one request.
  typedef struct packed {
    logic              lead;
    logic              trail;
    logic [DATA_W-1:0] value;
    logic [LEN_W-1:0]  len_bytes;
  } gvrf_item_t;

  // Exponent all ones with a nonzero fraction, either sign.
  function automatic logic is_nan(input logic [DATA_W-1:0] b);
    return (b[30:23] == 8'hFF) && (b[22:0] != 23'd0);
  endfunction

endpackage

// File: hw/rtl/gvrf_regs.sv
// APB-style configuration registers of the grid value record framer.
// Depends on gvrf_pkg for the register indexes and the configuration struct.
module gvrf_regs (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_psel,
  input  logic                          cfg_penable,
  input  logic                          cfg_pwrite,
  input  logic [gvrf_pkg::ADDR_W-1:0]   cfg_paddr,
  input  logic [gvrf_pkg::DATA_W-1:0]   cfg_pwdata,
  output logic [gvrf_pkg::DATA_W-1:0]   cfg_prdata,
  output logic                          cfg_pready,
  output gvrf_pkg::gvrf_cfg_t           cfg
);
  import gvrf_pkg::*;

  gvrf_cfg_t cfg_r, cfg_nxt;
  logic      wr_en;

  assign cfg_pready = 1'b1;
  assign wr_en      = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      unique case (cfg_paddr[3:2])
        REG_UNDEFINED_VALUE: cfg_nxt.undefined_value = cfg_pwdata;
        REG_RECORD_VALUES:   cfg_nxt.record_values   = cfg_pwdata[RECV_W-1:0];
        REG_TOTAL_VALUES:    cfg_nxt.total_values    = cfg_pwdata[TOTAL_W-1:0];
        default:             cfg_nxt = cfg_r;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_paddr[3:2])
      REG_UNDEFINED_VALUE: cfg_prdata = cfg_r.undefined_value;
      REG_RECORD_VALUES:   cfg_prdata = DATA_W'(cfg_r.record_values);
      REG_TOTAL_VALUES:    cfg_prdata = DATA_W'(cfg_r.total_values);
      default:             cfg_prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.undefined_value <= UNDEF_RESET;
      cfg_r.record_values   <= RECV_RESET;
      cfg_r.total_values    <= TOTAL_RESET;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

// File: hw/rtl/gvrf_track.sv
// Surface and record counters of the grid value record framer; forms the item
// for each accepted value. Depends on gvrf_pkg.
module gvrf_track #(
  parameter int COUNT_WIDTH = gvrf_pkg::COUNT_WIDTH_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  gvrf_pkg::gvrf_cfg_t         cfg,
  input  logic                        in_accept,
  input  logic [gvrf_pkg::DATA_W-1:0] in_value,
  output gvrf_pkg::gvrf_item_t        item
);
  import gvrf_pkg::*;

  logic [COUNT_WIDTH-1:0] values_left_r, values_left_nxt;
  logic [RECV_W-1:0]      words_in_record_r, words_in_record_nxt;
  logic [RECV_W-1:0]      record_length_r, record_length_nxt;

  logic [31:0]            tot_ext;
  logic [COUNT_WIDTH-1:0] tot_cut;
  logic                   reload;
  logic [COUNT_WIDTH-1:0] vl;
  logic [RECV_W-1:0]      wir;
  logic [RECV_W-1:0]      wir_inc;
  logic [RECV_W-1:0]      rv;
  logic [RECV_W-1:0]      rl;
  logic                   lead;
  logic                   trail;

  always_comb begin
    tot_ext = 32'(cfg.total_values);
    tot_cut = tot_ext[COUNT_WIDTH-1:0];
    reload  = (values_left_r == '0);
    // An exhausted count starts a new surface; a zero size acts as one.
    if (reload) begin
      vl  = (tot_cut == '0) ? COUNT_WIDTH'(1) : tot_cut;
      wir = '0;
    end else begin
      vl  = values_left_r;
      wir = words_in_record_r;
    end
    lead = (wir == '0);
    rv   = (cfg.record_values == '0) ? RECV_W'(1) : cfg.record_values;
    if (lead) begin
      rl = (32'(vl) < 32'(rv)) ? vl[RECV_W-1:0] : rv;
    end else begin
      rl = record_length_r;
    end
    wir_inc = wir + RECV_W'(1);
    trail   = (wir_inc >= rl);

    values_left_nxt     = vl - COUNT_WIDTH'(1);
    words_in_record_nxt = trail ? '0 : wir_inc;
    record_length_nxt   = rl;

    item.lead      = lead;
    item.trail     = trail;
    item.value     = is_nan(in_value) ? cfg.undefined_value : in_value;
    item.len_bytes = {rl, 2'b00};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      values_left_r     <= '0;
      words_in_record_r <= '0;
      record_length_r   <= '0;
    end else if (in_accept) begin
      values_left_r     <= values_left_nxt;
      words_in_record_r <= words_in_record_nxt;
      record_length_r   <= record_length_nxt;
    end
  end

endmodule

// File: hw/rtl/gvrf_emit.sv
// Result register and word sequencer of the grid value record framer: holds one
// item and hands out its one to three words. Depends on gvrf_pkg.
module gvrf_emit (
  input  logic                        clk,
  input  logic                        rst_n,
  input  gvrf_pkg::gvrf_item_t        item_in,
  input  logic                        in_tvalid,
  output logic                        in_tready,
  output logic                        in_accept,
  output logic                        out_tvalid,
  input  logic                        out_tready,
  output logic [gvrf_pkg::DATA_W-1:0] out_tdata,
  output logic [1:0]                  out_tuser,
  output logic                        out_tlast
);
  import gvrf_pkg::*;

  gvrf_item_t item_r;
  gvrf_kind_t kind_r, kind_nxt;
  logic       vld_r, vld_nxt;
  logic       take;
  logic       last;

  assign last = (kind_r == KIND_TRAIL) || ((kind_r == KIND_VALUE) && !item_r.trail);
  assign take = vld_r && out_tready;
  // The register frees up in the same cycle its final word is taken.
  assign in_tready = !vld_r || (take && last);
  assign in_accept = in_tvalid && in_tready;

  always_comb begin
    vld_nxt  = vld_r;
    kind_nxt = kind_r;
    if (in_accept) begin
      vld_nxt  = 1'b1;
      kind_nxt = item_in.lead ? KIND_LEAD : KIND_VALUE;
    end else if (take) begin
      if (last) begin
        vld_nxt = 1'b0;
      end else begin
        kind_nxt = (kind_r == KIND_LEAD) ? KIND_VALUE : KIND_TRAIL;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r  <= 1'b0;
      kind_r <= KIND_LEAD;
    end else begin
      vld_r  <= vld_nxt;
      kind_r <= kind_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      item_r <= item_in;
    end
  end

  always_comb begin
    unique case (kind_r)
      KIND_VALUE: out_tdata = item_r.value;
      KIND_LEAD:  out_tdata = DATA_W'(item_r.len_bytes);
      KIND_TRAIL: out_tdata = DATA_W'(item_r.len_bytes);
      default:    out_tdata = DATA_W'(item_r.len_bytes);
    endcase
  end

  assign out_tvalid = vld_r;
  assign out_tuser  = kind_r;
  assign out_tlast  = last;

endmodule

// File: hw/rtl/grid_value_record_framer.sv
// Channel  | Direction | Payload
// in_      | slave     | tdata[31:0] value_bits
// out_     | master    | tdata[31:0] out_word, tuser[1:0] word_kind, tlast last_of_run
// cfg_     | APB slave | 0x0 undefined_value, 0x4 record_values, 0x8 total_values
//
// Every request gives one to three words: one for a mid-record value, two at a record edge
// and three for a single-value record. The output port moves one word a cycle while
// out_tready is high; the single result register and its word sequencer set that rate.
// Reset (synchronous, rst_n low) empties the result register, zeroes the counters and
// loads the register defaults; no clearing pass is needed. A stall on out_tready holds
// the current word and blocks in_tready until the last word of the request is taken.
// Top level of the grid value record framer. Depends on gvrf_pkg, gvrf_regs,
// gvrf_track and gvrf_emit.
module grid_value_record_framer #(
  parameter int COUNT_WIDTH = gvrf_pkg::COUNT_WIDTH_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  // Input request stream.
  input  logic                        in_tvalid,
  output logic                        in_tready,
  input  logic [31:0]                 in_tdata,   // [31:0] value_bits
  // Result stream, one word per transfer.
  output logic                        out_tvalid,
  input  logic                        out_tready,
  output logic [31:0]                 out_tdata,  // [31:0] out_word
  output logic [1:0]                  out_tuser,  // [1:0] word_kind
  output logic                        out_tlast,
  // Configuration port.
  input  logic                        cfg_psel,
  input  logic                        cfg_penable,
  input  logic                        cfg_pwrite,
  input  logic [gvrf_pkg::ADDR_W-1:0] cfg_paddr,
  input  logic [31:0]                 cfg_pwdata,
  output logic [31:0]                 cfg_prdata,
  output logic                        cfg_pready
);
  import gvrf_pkg::*;

  gvrf_cfg_t  cfg;
  gvrf_item_t item;
  logic       in_accept;

  // Register file; values are taken up by the counters when the next request needs them.
  gvrf_regs u_regs (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready),
    .cfg         (cfg)
  );

  // Surface and record counting plus NaN substitution, all in the accepting cycle.
  gvrf_track #(
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_track (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg),
    .in_accept (in_accept),
    .in_value  (in_tdata),
    .item      (item)
  );

  // Result register; it accepts the next request as its last word leaves.
  gvrf_emit u_emit (
    .clk        (clk),
    .rst_n      (rst_n),
    .item_in    (item),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_accept  (in_accept),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

endmodule

// File: hw/rtl/gvrf_checker.sv
// Port-level checks of the grid value record framer and the bind that attaches them.
// Depends on gvrf_pkg and grid_value_record_framer_defines.svh.
`include "grid_value_record_framer_defines.svh"

module gvrf_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [31:0] out_tdata,
  input logic [1:0]  out_tuser,
  input logic        out_tlast
);
  import gvrf_pkg::*;

  // A leading marker never ends a request; a trailing marker always does.
  `GVRF_ASSERT_IMPL(a_lead_not_last, out_tvalid && (out_tuser == KIND_LEAD), !out_tlast)
  `GVRF_ASSERT_IMPL(a_trail_is_last, out_tvalid && (out_tuser == KIND_TRAIL), out_tlast)
  // A leading marker is followed at once by its value.
  `GVRF_ASSERT_NEXT(a_lead_then_value,
    out_tvalid && out_tready && (out_tuser == KIND_LEAD),
    out_tvalid && (out_tuser == KIND_VALUE))
  // A stalled word holds.
  `GVRF_ASSERT_NEXT(a_stall_holds, out_tvalid && !out_tready,
    out_tvalid && $stable(out_tdata) && $stable(out_tuser))

endmodule

bind grid_value_record_framer gvrf_checker u_gvrf_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser),
  .out_tlast  (out_tlast)
);
